### sv/arl_pkg.sv
// Shared types and constants for the antialiased line rasterizer.
// Used by arl_ctrl, arl_datapath and antialiased_line_rasterizer_core.
`default_nettype none
package arl_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int PX_BITS    = 11;
  localparam int LEVEL_BITS = 8;
  localparam int SLOPE_BITS = FRAC_BITS + 2;
  localparam int ACC_BITS   = PX_BITS + FRAC_BITS;
  localparam int DVD_BITS   = COORD_BITS + FRAC_BITS;
  localparam int DIV_STEPS  = DVD_BITS;
  localparam int CNT_BITS   = $clog2(DIV_STEPS);
  localparam int MULT_BITS  = FRAC_BITS + 1 + LEVEL_BITS;

  localparam logic [LEVEL_BITS-1:0] HALF_LEVEL =
    LEVEL_BITS'((((64'd1 << FRAC_BITS) >> 1) * 64'd255) >> FRAC_BITS);
  localparam logic [LEVEL_BITS-1:0] LEVEL_SCALE = LEVEL_BITS'(255);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_FINISH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_INTERIOR
  } phase_t;

  typedef struct packed {
    logic                  mode;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [PX_BITS-1:0]    near_px_x;
    logic [PX_BITS-1:0]    near_px_y;
    logic [LEVEL_BITS-1:0] near_level;
    logic [PX_BITS-1:0]    far_px_x;
    logic [PX_BITS-1:0]    far_px_y;
    logic [LEVEL_BITS-1:0] far_level;
    logic                  last_column;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_finish;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic line_active;
  } dp_status_t;

endpackage
`default_nettype wire

### sv/arl_ctrl.sv
// Controller for the line rasterizer: handshakes, divide sequencing, output valid.
// Depends on arl_pkg; drives arl_datapath through dp_cmd_t.
`default_nettype none
module arl_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_mode,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire arl_pkg::dp_status_t  status,
  output arl_pkg::dp_cmd_t          cmd
);

  arl_pkg::ctrl_state_t state_r, state_nxt;
  logic [arl_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arl_pkg::ST_RUN;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    accept        = 1'b0;
    // drop the held result once it transfers
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      arl_pkg::ST_RUN: begin
        in_ready = !out_valid_r || out_ready;
        accept   = in_valid && in_ready;
        if (accept) begin
          if (in_mode == arl_pkg::MODE_LOAD) begin
            cmd.load  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = arl_pkg::ST_DIV;
          end else if (status.line_active) begin
            cmd.emit      = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      arl_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == arl_pkg::CNT_BITS'(arl_pkg::DIV_STEPS - 1)) begin
          state_nxt = arl_pkg::ST_FINISH;
        end
      end
      arl_pkg::ST_FINISH: begin
        cmd.div_finish = 1'b1;
        state_nxt      = arl_pkg::ST_RUN;
      end
      default: begin
        state_nxt = arl_pkg::ST_RUN;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### sv/arl_datapath.sv
// Datapath for the line rasterizer: endpoint setup, restoring slope divider,
// minor-axis accumulator and result register. Depends on arl_pkg.
`default_nettype none
module arl_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire arl_pkg::in_item_t   in_data,
  input  wire arl_pkg::dp_cmd_t    cmd,
  output arl_pkg::dp_status_t      status,
  output arl_pkg::out_item_t       out_data
);

  localparam int CB = arl_pkg::COORD_BITS;
  localparam int FB = arl_pkg::FRAC_BITS;
  localparam int PB = arl_pkg::PX_BITS;
  localparam int LB = arl_pkg::LEVEL_BITS;
  localparam int SB = arl_pkg::SLOPE_BITS;
  localparam int AB = arl_pkg::ACC_BITS;
  localparam int DB = arl_pkg::DVD_BITS;
  localparam int MB = arl_pkg::MULT_BITS;

  // line registers
  logic               active_r, active_nxt;
  arl_pkg::phase_t    phase_r, phase_nxt;
  logic               steep_r;
  logic               neg_r;
  logic [CB-1:0]      major_first_r, major_last_r, minor_first_r, minor_last_r;
  logic [CB-1:0]      dx_r;
  logic [CB-1:0]      rem_r;
  logic [DB-1:0]      dvd_r;
  logic [SB-1:0]      slope_r;
  logic [AB-1:0]      accum_r;
  logic [PB-1:0]      cursor_r;
  arl_pkg::out_item_t out_r, out_nxt;

  // load setup
  logic [CB-1:0] adx, ady, a0, b0, a1, b1, ld_dx, ld_mag;
  logic          ld_steep, ld_neg;

  always_comb begin
    adx = (in_data.end_x > in_data.start_x) ? in_data.end_x - in_data.start_x
                                            : in_data.start_x - in_data.end_x;
    ady = (in_data.end_y > in_data.start_y) ? in_data.end_y - in_data.start_y
                                            : in_data.start_y - in_data.end_y;
    ld_steep = ady > adx;
    a0 = ld_steep ? in_data.start_y : in_data.start_x;
    b0 = ld_steep ? in_data.start_x : in_data.start_y;
    a1 = ld_steep ? in_data.end_y   : in_data.end_x;
    b1 = ld_steep ? in_data.end_x   : in_data.end_y;
    if (a0 > a1) begin
      a0 = ld_steep ? in_data.end_y   : in_data.end_x;
      b0 = ld_steep ? in_data.end_x   : in_data.end_y;
      a1 = ld_steep ? in_data.start_y : in_data.start_x;
      b1 = ld_steep ? in_data.start_x : in_data.start_y;
    end
    ld_dx  = a1 - a0;
    ld_neg = b1 < b0;
    ld_mag = ld_neg ? b0 - b1 : b1 - b0;
  end

  // one restoring divide step per cycle; quotient bits shift in below the dividend
  logic [CB:0]   rem_sh;
  logic          q_bit;
  logic [CB-1:0] rem_step;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[DB-1]};
    q_bit    = rem_sh >= {1'b0, dx_r};
    rem_step = q_bit ? CB'(rem_sh - {1'b0, dx_r}) : rem_sh[CB-1:0];
  end

  // finish: signed gradient, 1.0 for a zero-length major span
  logic [FB:0]   g_mag;
  logic [SB-1:0] g_signed;

  always_comb begin
    g_mag    = (dx_r == '0) ? (FB+1)'(1) << FB : dvd_r[FB:0];
    g_signed = neg_r ? SB'(-{1'b0, g_mag}) : {1'b0, g_mag};
  end

  // column emission
  logic [PB-1:0]   col_major, col_minor, far_minor;
  logic [LB-1:0]   col_nl, col_fl;
  logic            col_last;
  logic [FB-1:0]   frac;
  logic [FB:0]     inv_frac;
  logic [MB-1:0]   nl_prod, fl_prod;
  logic [PB:0]     cursor_inc;
  logic [PB-1:0]   first_inc;

  always_comb begin
    frac       = accum_r[FB-1:0];
    inv_frac   = ((FB+1)'(1) << FB) - {1'b0, frac};
    nl_prod    = MB'(inv_frac) * MB'(arl_pkg::LEVEL_SCALE);
    fl_prod    = MB'(frac) * MB'(arl_pkg::LEVEL_SCALE);
    cursor_inc = {1'b0, cursor_r} + 1'b1;
    first_inc  = PB'(major_first_r) + 1'b1;
    col_major  = cursor_r;
    col_minor  = accum_r[AB-1:FB];
    col_nl     = nl_prod[FB +: LB];
    col_fl     = fl_prod[FB +: LB];
    col_last   = cursor_inc >= (PB+1)'(major_last_r);
    phase_nxt  = phase_r;
    active_nxt = active_r;
    unique case (phase_r)
      arl_pkg::PH_FIRST: begin
        col_major = PB'(major_first_r);
        col_minor = PB'(minor_first_r);
        col_nl    = arl_pkg::HALF_LEVEL;
        col_fl    = '0;
        col_last  = 1'b0;
        phase_nxt = arl_pkg::PH_SECOND;
      end
      arl_pkg::PH_SECOND: begin
        col_major = PB'(major_last_r);
        col_minor = PB'(minor_last_r);
        col_nl    = arl_pkg::HALF_LEVEL;
        col_fl    = '0;
        col_last  = PB'(major_last_r) <= first_inc;
        phase_nxt = arl_pkg::PH_INTERIOR;
      end
      arl_pkg::PH_INTERIOR: begin
        phase_nxt = arl_pkg::PH_INTERIOR;
      end
      default: begin
        phase_nxt = arl_pkg::PH_INTERIOR;
      end
    endcase
    far_minor = col_minor + 1'b1;
    if (col_last) begin
      active_nxt = 1'b0;
    end
    out_nxt.last_column = col_last;
    out_nxt.near_level  = col_nl;
    out_nxt.far_level   = col_fl;
    if (steep_r) begin
      out_nxt.near_px_x = col_minor;
      out_nxt.near_px_y = col_major;
      out_nxt.far_px_x  = far_minor;
      out_nxt.far_px_y  = col_major;
    end else begin
      out_nxt.near_px_x = col_major;
      out_nxt.near_px_y = col_minor;
      out_nxt.far_px_x  = col_major;
      out_nxt.far_px_y  = far_minor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phase_r  <= arl_pkg::PH_FIRST;
    end else if (cmd.load) begin
      active_r <= 1'b0;
      phase_r  <= arl_pkg::PH_FIRST;
    end else if (cmd.div_finish) begin
      active_r <= 1'b1;
      phase_r  <= arl_pkg::PH_FIRST;
    end else if (cmd.emit) begin
      active_r <= active_nxt;
      phase_r  <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      steep_r       <= ld_steep;
      neg_r         <= ld_neg;
      major_first_r <= a0;
      major_last_r  <= a1;
      minor_first_r <= b0;
      minor_last_r  <= b1;
      dx_r          <= ld_dx;
      rem_r         <= '0;
      dvd_r         <= {ld_mag, {FB{1'b0}}};
    end
    if (cmd.div_step) begin
      rem_r <= rem_step;
      dvd_r <= {dvd_r[DB-2:0], q_bit};
    end
    if (cmd.div_finish) begin
      slope_r  <= g_signed;
      accum_r  <= {PB'(minor_first_r), {FB{1'b0}}} + {{(AB-SB){g_signed[SB-1]}}, g_signed};
      cursor_r <= first_inc;
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
      if (phase_r == arl_pkg::PH_INTERIOR) begin
        // advance one interior column
        accum_r  <= accum_r + {{(AB-SB){slope_r[SB-1]}}, slope_r};
        cursor_r <= cursor_inc[PB-1:0];
      end
    end
  end

  assign status.line_active = active_r;
  assign out_data           = out_r;

endmodule
`default_nettype wire

### sv/antialiased_line_rasterizer_core.sv
// Top level of the antialiased line rasterizer: controller plus datapath.
// Depends on arl_pkg, arl_ctrl and arl_datapath.
//
// A load item (mode 0) holds off the next item while it is processed: a setup
// step, the bit-per-cycle restoring divider that forms the Q1.16 gradient,
// and a final step to seed the minor accumulator. A step item (mode 1) writes
// its column into the output register on the next edge; steps transfer at one
// per cycle while the result side keeps taking them. A load produces no
// result; a step with no line in progress is accepted and produces none.
// Columns come out as first endpoint, second endpoint, then the interior
// columns, with last_column on the final one.
`default_nettype none
module antialiased_line_rasterizer_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire arl_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output arl_pkg::out_item_t      out_data
);

  arl_pkg::dp_cmd_t    cmd;
  arl_pkg::dp_status_t status;

  arl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  arl_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  // a load holds off the input side while the divider runs
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.mode == arl_pkg::MODE_LOAD)) |=> !in_ready)
    else $error("input accepted during slope division");

  // a step on an active line yields a column; the last flag ends the line
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.mode == arl_pkg::MODE_STEP) && status.line_active)
    |=> (out_valid && (out_data.last_column != status.line_active)))
    else $error("step on active line gave no column or wrong last flag");

  // a step with no line in progress produces nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.mode == arl_pkg::MODE_STEP) &&
     !status.line_active && (!out_valid || out_ready)) |=> !out_valid)
    else $error("step while idle produced a column");

endmodule
`default_nettype wire

### tb/antialiased_line_rasterizer_core_tb.sv
// Testbench for antialiased_line_rasterizer_core: directed table, then random line walks, each
// column checked against its known value (directed step rows) or a cycle-free Wu line predictor.
// Depends on arl_pkg and antialiased_line_rasterizer_core.
`default_nettype none
module antialiased_line_rasterizer_core_tb;

  localparam int COORD_MAX = (1 << arl_pkg::COORD_BITS) - 1;
  localparam longint unsigned ONE_Q = 64'd1 << arl_pkg::FRAC_BITS;
  localparam longint unsigned HALF_COVER = ((ONE_Q >> 1) * 255) >> arl_pkg::FRAC_BITS;
  localparam longint unsigned FULL_COVER = 255;
  localparam int ITEM_GOAL = 1750;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    arl_pkg::in_item_t  item;
    logic               typed;
    arl_pkg::out_item_t col;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  arl_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  arl_pkg::out_item_t out_data;

  antialiased_line_rasterizer_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Line state of the predictor
  bit                line_on;
  bit                steep_q;
  arl_pkg::phase_t   col_phase;
  longint unsigned   maj_first, maj_last, maj_cur;
  longint unsigned   min_first, min_last;
  longint unsigned   grad, min_acc;

  arl_pkg::out_item_t pending_cols[$];
  dir_row_t           dir_rows[$];

  int  err_count, items_sent, loads_sent, steep_loads, cols_seen, lines_done;
  bit  tx_burst, rx_burst, hold_req, hold_done;
  int  hold_left, stall_left, rx_left, rx_pick;

  function automatic arl_pkg::out_item_t make_column(longint unsigned maj,
                                                     longint unsigned mnr,
                                                     longint unsigned nl,
                                                     longint unsigned fl,
                                                     bit last);
    arl_pkg::out_item_t c;
    logic [arl_pkg::PX_BITS-1:0] mj, mn, mf;
    mj = arl_pkg::PX_BITS'(maj);
    mn = arl_pkg::PX_BITS'(mnr);
    mf = arl_pkg::PX_BITS'(mnr + 1);
    if (steep_q) begin
      c.near_px_x = mn; c.near_px_y = mj;
      c.far_px_x  = mf; c.far_px_y  = mj;
    end else begin
      c.near_px_x = mj; c.near_px_y = mn;
      c.far_px_x  = mj; c.far_px_y  = mf;
    end
    c.near_level  = arl_pkg::LEVEL_BITS'(nl);
    c.far_level   = arl_pkg::LEVEL_BITS'(fl);
    c.last_column = last;
    return c;
  endfunction

  // Advance the line state by one transfer; return 1 when a column comes out.
  function automatic bit rasterize_item(input arl_pkg::in_item_t it,
                                        output arl_pkg::out_item_t col);
    longint unsigned x0, y0, x1, y1, adx, ady, a0, b0, a1, b1, t, span, mag, g;
    longint unsigned frac, nl, fl;
    bit neg, last;
    col = '0;
    if (it.mode == arl_pkg::MODE_LOAD) begin
      x0 = it.start_x; y0 = it.start_y;
      x1 = it.end_x;   y1 = it.end_y;
      adx = x1 > x0 ? x1 - x0 : x0 - x1;
      ady = y1 > y0 ? y1 - y0 : y0 - y1;
      steep_q = ady > adx;
      if (steep_q) begin
        a0 = y0; b0 = x0; a1 = y1; b1 = x1;
      end else begin
        a0 = x0; b0 = y0; a1 = x1; b1 = y1;
      end
      if (a0 > a1) begin
        t = a0; a0 = a1; a1 = t;
        t = b0; b0 = b1; b1 = t;
      end
      span = a1 - a0;
      neg = b1 < b0;
      mag = neg ? b0 - b1 : b1 - b0;
      if (span == 0) begin
        g = ONE_Q;
      end else begin
        g = (mag << arl_pkg::FRAC_BITS) / span;
        if (neg) g = 64'd0 - g;
      end
      maj_first = a0; maj_last = a1;
      min_first = b0; min_last = b1;
      grad      = g;
      min_acc   = (b0 << arl_pkg::FRAC_BITS) + g;
      maj_cur   = a0 + 1;
      col_phase = arl_pkg::PH_FIRST;
      line_on   = 1'b1;
      return 1'b0;
    end
    if (!line_on) return 1'b0;
    case (col_phase)
      arl_pkg::PH_FIRST: begin
        col = make_column(maj_first, min_first, HALF_COVER, 0, 1'b0);
        col_phase = arl_pkg::PH_SECOND;
      end
      arl_pkg::PH_SECOND: begin
        last = maj_last <= maj_first + 1;
        col = make_column(maj_last, min_last, HALF_COVER, 0, last);
        col_phase = arl_pkg::PH_INTERIOR;
        if (last) line_on = 1'b0;
      end
      default: begin
        frac = min_acc & (ONE_Q - 1);
        nl   = ((ONE_Q - frac) * 255) >> arl_pkg::FRAC_BITS;
        fl   = (frac * 255) >> arl_pkg::FRAC_BITS;
        last = maj_cur + 1 >= maj_last;
        col = make_column(maj_cur, min_acc >> arl_pkg::FRAC_BITS, nl, fl, last);
        min_acc = min_acc + grad;
        maj_cur = maj_cur + 1;
        if (last) line_on = 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic arl_pkg::in_item_t make_item(logic m, int x0, int y0, int x1, int y1);
    arl_pkg::in_item_t it;
    it.mode    = m;
    it.start_x = arl_pkg::COORD_BITS'(x0);
    it.start_y = arl_pkg::COORD_BITS'(y0);
    it.end_x   = arl_pkg::COORD_BITS'(x1);
    it.end_y   = arl_pkg::COORD_BITS'(y1);
    return it;
  endfunction

  function automatic arl_pkg::in_item_t random_item(logic m);
    return make_item(m, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
  endfunction

  function automatic int near_coord(int c, int reach);
    int v;
    v = c + int'($urandom_range(0, 2 * reach)) - reach;
    return v < 0 ? 0 : (v > COORD_MAX ? COORD_MAX : v);
  endfunction

  function automatic void row(logic m, int x0, int y0, int x1, int y1);
    dir_row_t r;
    r.item  = make_item(m, x0, y0, x1, y1);
    r.typed = 1'b0;
    r.col   = '0;
    dir_rows.push_back(r);
  endfunction

  // Step row whose column is known up front
  function automatic void col_row(int nx, int ny, longint unsigned nl,
                                  int fx, int fy, longint unsigned fl, bit last);
    dir_row_t r;
    r.item  = make_item(arl_pkg::MODE_STEP, 0, 0, 0, 0);
    r.typed = 1'b1;
    r.col   = '{near_px_x: arl_pkg::PX_BITS'(nx), near_px_y: arl_pkg::PX_BITS'(ny),
                near_level: arl_pkg::LEVEL_BITS'(nl), far_px_x: arl_pkg::PX_BITS'(fx),
                far_px_y: arl_pkg::PX_BITS'(fy), far_level: arl_pkg::LEVEL_BITS'(fl),
                last_column: last};
    dir_rows.push_back(r);
  endfunction

  function automatic string col_str(arl_pkg::out_item_t c);
    return $sformatf("near (%0d,%0d) lvl %0d far (%0d,%0d) lvl %0d last %0b",
                     c.near_px_x, c.near_px_y, c.near_level,
                     c.far_px_x, c.far_px_y, c.far_level, c.last_column);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input arl_pkg::in_item_t it, input bit typed,
                           input arl_pkg::out_item_t col);
    int gap;
    bit counts, got;
    arl_pkg::out_item_t pred;
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    // transfer happened at this edge
    counts = (it.mode == arl_pkg::MODE_LOAD) || line_on;
    got = rasterize_item(it, pred);
    if (counts) items_sent++;
    if (it.mode == arl_pkg::MODE_LOAD) begin
      loads_sent++;
      if (steep_q) steep_loads++;
    end
    if (got) pending_cols.push_back(typed ? col : pred);
  endtask

  task automatic send_pred(input arl_pkg::in_item_t it);
    send_item(it, 1'b0, '0);
  endtask

  task automatic check_column(input arl_pkg::out_item_t got);
    arl_pkg::out_item_t want;
    cols_seen++;
    if (got.last_column) lines_done++;
    if (pending_cols.size() == 0) begin
      err_count++;
      if (err_count <= 10) $display("ERROR: column with nothing pending: %s", col_str(got));
    end else begin
      want = pending_cols.pop_front();
      if (got.near_px_x !== want.near_px_x || got.near_px_y !== want.near_px_y ||
          got.near_level !== want.near_level || got.far_px_x !== want.far_px_x ||
          got.far_px_y !== want.far_px_y || got.far_level !== want.far_level ||
          got.last_column !== want.last_column) begin
        err_count++;
        if (err_count <= 10) begin
          $display("ERROR: column %0d mismatch", cols_seen);
          $display("  expected %s", col_str(want));
          $display("  actual   %s", col_str(got));
        end
      end
    end
  endtask

  // Result side: check transfers, then pick ready for the next cycle
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_column(out_data);
      if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (rx_left == 0) begin
        rx_burst = ($urandom_range(0, 3) == 0);
        rx_left  = $urandom_range(30, 200);
      end else begin
        rx_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_burst) begin
        out_ready <= 1'b1;
      end else begin
        rx_pick = $urandom_range(0, 99);
        if (rx_pick < 3) begin
          stall_left = $urandom_range(5, 40);
          out_ready <= 1'b0;
        end else begin
          out_ready <= (rx_pick >= 25);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d columns still pending", pending_cols.size());
    $display("antialiased_line_rasterizer_core_tb failed");
    $finish;
  end

  initial begin
    int x0, y0, x1, y1, pick, shape, n, d;

    row(arl_pkg::MODE_STEP, 0, 0, 0, 0);                  // step with no line
    row(arl_pkg::MODE_LOAD, 0, 0, COORD_MAX, COORD_MAX);  // full diagonal, gradient 1.0
    col_row(0, 0, HALF_COVER, 0, 1, 0, 0);
    col_row(COORD_MAX, COORD_MAX, HALF_COVER, COORD_MAX, COORD_MAX + 1, 0, 0);
    row(arl_pkg::MODE_STEP, 0, 0, 0, 0);
    // reload mid-line, single point
    row(arl_pkg::MODE_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    col_row(COORD_MAX, COORD_MAX, HALF_COVER, COORD_MAX, COORD_MAX + 1, 0, 0);
    col_row(COORD_MAX, COORD_MAX, HALF_COVER, COORD_MAX, COORD_MAX + 1, 0, 1);
    // idle again
    row(arl_pkg::MODE_STEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    row(arl_pkg::MODE_LOAD, 0, COORD_MAX, 1, 0);          // steep, negative gradient
    col_row(1, 0, HALF_COVER, 2, 0, 0, 0);
    col_row(0, COORD_MAX, HALF_COVER, 1, COORD_MAX, 0, 0);
    row(arl_pkg::MODE_STEP, 0, 0, 0, 0);
    row(arl_pkg::MODE_LOAD, 0, 512, COORD_MAX, 512);      // horizontal, zero gradient
    col_row(0, 512, HALF_COVER, 0, 513, 0, 0);
    col_row(COORD_MAX, 512, HALF_COVER, COORD_MAX, 513, 0, 0);
    col_row(1, 512, FULL_COVER, 1, 513, 0, 0);
    row(arl_pkg::MODE_LOAD, 6, 3, 5, 3);                  // reversed, no interior column
    col_row(5, 3, HALF_COVER, 5, 4, 0, 0);
    col_row(6, 3, HALF_COVER, 6, 4, 0, 1);
    row(arl_pkg::MODE_LOAD, 0, 0, 3, 2);                  // fractional interior
    repeat (4) row(arl_pkg::MODE_STEP, 0, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].col);

    // Long shallow line sent back to back while the result side holds off
    tx_burst = 1'b1;
    send_pred(make_item(arl_pkg::MODE_LOAD, 0, 100, 400, 37));
    n = 0;
    while (line_on) begin
      send_pred(random_item(arl_pkg::MODE_STEP));
      n++;
      if (n == 3) hold_req = 1'b1;
    end

    while (items_sent < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      tx_burst = ($urandom_range(0, 4) == 0);
      if (pick < 80) begin
        x0 = $urandom_range(0, COORD_MAX);
        y0 = $urandom_range(0, COORD_MAX);
        shape = $urandom_range(0, 99);
        if (shape < 2) begin
          x1 = $urandom_range(0, COORD_MAX);
          y1 = $urandom_range(0, COORD_MAX);
        end else if (shape < 10) begin
          x1 = x0;
          y1 = near_coord(y0, 24);
        end else if (shape < 18) begin
          x1 = near_coord(x0, 24);
          y1 = y0;
        end else if (shape < 26) begin
          d  = $urandom_range(0, 20);
          x1 = x0 + d > COORD_MAX ? x0 - d : x0 + d;
          y1 = ($urandom_range(0, 1) && y0 >= d) ? y0 - d
                                                 : (y0 + d > COORD_MAX ? y0 - d : y0 + d);
        end else if (shape < 29) begin
          x1 = x0;
          y1 = y0;
        end else begin
          x1 = near_coord(x0, 24);
          y1 = near_coord(y0, 24);
        end
        send_pred(make_item(arl_pkg::MODE_LOAD, x0, y0, x1, y1));
        while (line_on) send_pred(random_item(arl_pkg::MODE_STEP));
        if ($urandom_range(0, 9) == 0) send_pred(random_item(arl_pkg::MODE_STEP));
      end else if (pick < 90) begin
        // cut a line short; the next load drops it
        send_pred(random_item(arl_pkg::MODE_LOAD));
        repeat ($urandom_range(0, 5)) if (line_on) send_pred(random_item(arl_pkg::MODE_STEP));
      end else begin
        repeat ($urandom_range(1, 4)) send_pred(random_item(logic'($urandom_range(0, 1))));
      end
    end

    in_valid <= 1'b0;
    while (pending_cols.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d items: %0d line loads (%0d steep), rest column steps.",
             items_sent, loads_sent, steep_loads);
    $display("Checked %0d columns over %0d completed lines; %0d errors.",
             cols_seen, lines_done, err_count);
    if (err_count == 0) begin
      $display("antialiased_line_rasterizer_core_tb passed");
    end else begin
      $display("antialiased_line_rasterizer_core_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
sv/arl_pkg.sv
sv/arl_ctrl.sv
sv/arl_datapath.sv
sv/antialiased_line_rasterizer_core.sv
tb/antialiased_line_rasterizer_core_tb.sv
